/* design/clock_synced_lfo_channel_macros.svh */
// Assertion macros shared by the clock-synced LFO channel design.
`ifndef CLOCK_SYNCED_LFO_CHANNEL_MACROS_SVH
`define CLOCK_SYNCED_LFO_CHANNEL_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a condition at every clock edge outside reset.
`define CSLFO_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("cslfo assertion failed");
// Checks that a trigger is followed by a consequence in the next cycle.
`define CSLFO_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("cslfo assertion failed");
`else
`define CSLFO_ASSERT(lbl, cond)
`define CSLFO_ASSERT_NEXT(lbl, trig, cons)
`endif
`endif

/* design/cslfo_pkg.sv */
// Shared types, constants and table builders for the clock-synced LFO channel.
package cslfo_pkg;

    localparam int CSLFO_MAX_RATIO  = 32;
    localparam int CSLFO_TABLE_BITS = 10;
    localparam int DIV_STEPS        = 32;
    localparam int CNT_W            = 5;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int LVL_W            = 17;
    localparam int LVL_LIMIT        = 61440;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_SHAPE, CFG_RATE_SETTING, CFG_PHASE_SHIFT, CFG_WARP_AMOUNT,
        CFG_LEVEL_OFFSET, CFG_SCALE_PERCENT, CFG_INVERT_WAVE, CFG_DIVIDE_MODE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHAPE_RAMP, SHAPE_TRIANGLE, SHAPE_SINE, SHAPE_SQUARE
    } t_shape;

    typedef enum logic [4:0] {
        ST_IDLE, ST_UPD, ST_DIV, ST_PHD, ST_CRV1, ST_CRV2, ST_CRV3, ST_CRV4,
        ST_SQR, ST_SN0, ST_SN1, ST_SN2, ST_SN3, ST_SN4, ST_SCL1, ST_SCL2,
        ST_COR, ST_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_TAKE, OP_UPD, OP_DIV, OP_PHD, OP_CRV1, OP_CRV2, OP_CRV3,
        OP_CRV4, OP_SQR, OP_SN0, OP_SN1, OP_SN2, OP_SN3, OP_SN4, OP_SCL1,
        OP_SCL2, OP_COR, OP_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic   play;
        logic   mul_mode;
        t_shape shape;
    } t_stat;

    // Integer square root of a 64-bit value, used only at elaboration.
    function automatic logic [63:0] f_isqrt(input logic [63:0] a);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = a;
        res   = '0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // log2(1 + k / 2^tb) in Q0.16, by repeated squaring.
    function automatic logic [15:0] f_log_entry(input int k, input int tb);
        logic [63:0] y;
        logic [15:0] r;
        int i;
        y = (64'd1 << 30) + (64'(k) << (30 - tb));
        r = '0;
        for (i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            r = {r[14:0], 1'b0};
            if (y >= (64'd2 << 30)) begin
                y    = y >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    // 2^(k / 2^tb) in Q1.16, from products of repeated square roots of two.
    function automatic logic [16:0] f_exp_entry(input int k, input int tb);
        logic [63:0] roots [17];
        logic [63:0] acc;
        logic [15:0] f;
        int i;
        roots[0] = 64'd2 << 30;
        for (i = 1; i <= 16; i++) roots[i] = f_isqrt(roots[i-1] << 30);
        acc = 64'd1 << 30;
        f   = 16'(k << (16 - tb));
        for (i = 1; i <= 16; i++) begin
            if (f[16-i]) acc = (acc * roots[i]) >> 30;
        end
        return 17'(acc >> 14);
    endfunction

endpackage

/* design/cslfo_ctrl.sv */
// Sequencer for one LFO step: walks the datapath through its operations.
module cslfo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  cslfo_pkg::t_stat i_stat,
    output cslfo_pkg::t_cmd  o_cmd
);
    import cslfo_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd.op  = OP_NONE;
        n_out_vld = r_out_vld && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.op = OP_UPD;
                n_cnt    = '0;
                if (!i_stat.play) n_state = ST_FIN;
                else if (!i_stat.mul_mode) n_state = ST_DIV;
                else if (i_stat.shape == SHAPE_SQUARE) n_state = ST_SQR;
                else n_state = ST_CRV1;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = ST_PHD;
            end
            ST_PHD: begin
                o_cmd.op = OP_PHD;
                n_state  = (i_stat.shape == SHAPE_SQUARE) ? ST_SQR : ST_CRV1;
            end
            ST_CRV1: begin o_cmd.op = OP_CRV1; n_state = ST_CRV2; end
            ST_CRV2: begin o_cmd.op = OP_CRV2; n_state = ST_CRV3; end
            ST_CRV3: begin o_cmd.op = OP_CRV3; n_state = ST_CRV4; end
            ST_CRV4: begin
                o_cmd.op = OP_CRV4;
                n_state  = (i_stat.shape == SHAPE_SINE) ? ST_SN0 : ST_SCL1;
            end
            ST_SQR:  begin o_cmd.op = OP_SQR;  n_state = ST_SCL1; end
            ST_SN0:  begin o_cmd.op = OP_SN0;  n_state = ST_SN1; end
            ST_SN1:  begin o_cmd.op = OP_SN1;  n_state = ST_SN2; end
            ST_SN2:  begin o_cmd.op = OP_SN2;  n_state = ST_SN3; end
            ST_SN3:  begin o_cmd.op = OP_SN3;  n_state = ST_SN4; end
            ST_SN4:  begin o_cmd.op = OP_SN4;  n_state = ST_SCL1; end
            ST_SCL1: begin o_cmd.op = OP_SCL1; n_state = ST_SCL2; end
            ST_SCL2: begin o_cmd.op = OP_SCL2; n_state = ST_COR; end
            ST_COR:  begin o_cmd.op = OP_COR;  n_state = ST_FIN; end
            ST_FIN: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.op  = OP_LOAD;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

/* design/cslfo_dpath.sv */
// Datapath of the LFO channel: registers, divider, curve tables, shared multiplier.
module cslfo_dpath #(
    parameter int MAX_RATIO  = cslfo_pkg::CSLFO_MAX_RATIO,
    parameter int TABLE_BITS = cslfo_pkg::CSLFO_TABLE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cslfo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cslfo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]                      i_in_data,
    input  logic [1:0]                       i_in_user,
    input  cslfo_pkg::t_cmd                  i_cmd,
    output cslfo_pkg::t_stat                 o_stat,
    output logic [cslfo_pkg::LVL_W-1:0]      o_level
);
    import cslfo_pkg::*;

    localparam int TSIZE  = 1 << TABLE_BITS;
    localparam int TSHIFT = 16 - TABLE_BITS;
    localparam int RW     = $clog2(MAX_RATIO + 1);

    // Curve tables, built at elaboration.
    logic [15:0] log_rom [TSIZE];
    logic [16:0] exp_rom [TSIZE];
    for (genvar k = 0; k < TSIZE; k++) begin : g_rom
        localparam logic [15:0] LOG_V = f_log_entry(k, TABLE_BITS);
        localparam logic [16:0] EXP_V = f_exp_entry(k, TABLE_BITS);
        assign log_rom[k] = LOG_V;
        assign exp_rom[k] = EXP_V;
    end

    // Configuration.
    t_shape      r_shape;
    logic [6:0]  r_rate;
    logic [15:0] r_shift, r_warp, r_offs;
    logic [7:0]  r_scale;
    logic        r_inv, r_mode;

    // Channel state.
    logic [5:0]  r_dcnt;
    logic [15:0] r_last;
    logic        r_seen;

    // Item and working registers.
    logic [15:0]   r_clk, r_beat, r_ph;
    logic          r_rst, r_play;
    logic [31:0]   r_num;
    logic [RW-1:0] r_rem, r_div;
    logic [3:0]    r_p;
    logic          r_zero, r_big;
    logic [15:0]   r_log;
    logic [16:0]   r_exp, r_val, r_u, r_z, r_z2, r_a;
    logic [22:0]   r_nz;
    logic [5:0]    r_sh;
    logic [15:0]   r_y;
    logic [24:0]   r_prd;
    logic          r_neg;
    logic [16:0]   r_q;
    logic [LVL_W-1:0] r_lvl, r_out;

    // Shared multiplier.
    logic [20:0] mul_a;
    logic [17:0] mul_b;
    logic [38:0] mul_p;
    assign mul_p = 39'(mul_a) * 39'(mul_b);

    // Rate decode.
    logic signed [6:0] rate_s;
    logic              is_mul;
    logic [RW-1:0]     mul_f, div_f;
    logic [7:0]        rneg;
    assign rate_s = signed'(r_rate);
    assign is_mul = rate_s >= -7'sd1;
    assign rneg   = 8'd0 - {r_rate[6], r_rate};
    always_comb begin
        if (rate_s < 7'sd1) mul_f = RW'(1);
        else if (32'(rate_s) > MAX_RATIO) mul_f = RW'(MAX_RATIO);
        else mul_f = RW'(r_rate);
        if (32'(rneg) > MAX_RATIO) div_f = RW'(MAX_RATIO);
        else div_f = RW'(rneg);
    end

    // Restart and clock wrap handling.
    logic        rs_edge, wrap;
    logic [5:0]  cnt0, cnt1, cnt_n;
    logic [31:0] num_n;
    always_comb begin
        rs_edge = r_rst && !r_seen;
        wrap    = r_clk < (rs_edge ? r_clk : r_last);
        cnt0    = rs_edge ? 6'd0 : r_dcnt;
        cnt1    = cnt0 + 6'd1;
        cnt_n   = cnt0;
        if (r_play && !is_mul && wrap) begin
            cnt_n = (7'(cnt1) >= 7'(div_f)) ? 6'd0 : cnt1;
        end
        num_n = r_mode ? {10'd0, cnt_n, r_clk} : {r_beat, r_clk};
    end

    // Divider step.
    logic [RW:0] trial;
    logic        ge;
    assign trial = {r_rem, r_num[31]};
    assign ge    = trial >= {1'b0, r_div};

    // Curve front end.
    logic [3:0]  p_f;
    logic [15:0] xs, mant, nfrac;
    logic [15:0] t16;
    logic [TABLE_BITS-1:0] exp_idx;
    always_comb begin
        p_f = '0;
        for (int i = 0; i < 16; i++) begin
            if (r_ph[i]) p_f = 4'(i);
        end
        xs      = r_ph << (4'd15 - p_f);
        mant    = {xs[14:0], 1'b0};
        t16     = {r_warp[13:0], 2'b00};
        nfrac   = 16'd0 - r_nz[15:0];
        exp_idx = (i_cmd.op == OP_CRV1) ? t16[15:TSHIFT] : nfrac[15:TSHIFT];
    end

    logic [20:0] lmag;
    logic [19:0] ex20;
    logic [17:0] e_f;
    assign lmag = {5'd16 - {1'b0, r_p}, 16'd0} - 21'(r_log);
    assign ex20 = 20'(r_exp) << r_warp[15:14];
    assign e_f  = ex20[19:2];

    logic [16:0] ysh;
    assign ysh = r_val >> r_sh;

    // Sine and output helpers.
    logic [16:0] ui, s_f;
    logic [17:0] acc_f;
    logic [7:0]  smag;
    logic [18:0] x_f;
    logic [19:0] q5;
    logic [16:0] qc;
    logic signed [18:0] lv;
    logic [14:0] zq;
    assign zq    = 15'd16384 - 15'(r_y[13:0]);
    logic [16:0] z_sel;
    assign z_sel = r_y[14] ? {zq, 2'b00} : {1'b0, r_y[13:0], 2'b00};
    assign acc_f = mul_p[33:16];
    assign s_f   = (acc_f > 18'd65536) ? 17'd65536 : acc_f[16:0];
    assign ui    = r_inv ? 17'd65536 - r_u : r_u;
    assign smag  = r_scale[7] ? 8'd0 - r_scale : r_scale;
    assign x_f   = r_prd[23:5];
    assign q5    = {1'b0, r_q, 2'b00} + 20'(r_q);
    assign qc    = (q5 > 20'(x_f)) ? r_q - 17'd1 : r_q;
    assign lv    = (r_neg ? -19'(signed'({2'b00, qc})) : 19'(signed'({2'b00, qc})))
                   + 19'(signed'(r_offs));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_UPD:  begin mul_a = 21'(r_clk); mul_b = 18'(mul_f); end
            OP_CRV2: begin mul_a = lmag;       mul_b = e_f; end
            OP_SN0:  begin mul_a = 21'(z_sel); mul_b = 18'(z_sel); end
            OP_SN1:  begin mul_a = 21'(r_z2);  mul_b = 18'd307; end
            OP_SN2, OP_SN3: begin mul_a = 21'(r_z2); mul_b = 18'(r_a); end
            OP_SN4:  begin mul_a = 21'(r_z);   mul_b = 18'(r_a); end
            OP_SCL1: begin mul_a = 21'(ui);    mul_b = 18'(smag); end
            OP_SCL2: begin mul_a = 21'(x_f);   mul_b = 18'd52429; end
            default: ;
        endcase
    end

    // Configuration and channel state, reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_RAMP;
            r_rate  <= '0;
            r_shift <= '0;
            r_warp  <= 16'd32768;
            r_offs  <= '0;
            r_scale <= 8'd100;
            r_inv   <= 1'b0;
            r_mode  <= 1'b0;
            r_dcnt  <= '0;
            r_last  <= '0;
            r_seen  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WAVE_SHAPE:    r_shape <= t_shape'(i_cfg_data[1:0]);
                    CFG_RATE_SETTING:  r_rate  <= i_cfg_data[6:0];
                    CFG_PHASE_SHIFT:   r_shift <= i_cfg_data;
                    CFG_WARP_AMOUNT:   r_warp  <= i_cfg_data;
                    CFG_LEVEL_OFFSET:  r_offs  <= i_cfg_data;
                    CFG_SCALE_PERCENT: r_scale <= i_cfg_data[7:0];
                    CFG_INVERT_WAVE:   r_inv   <= i_cfg_data[0];
                    CFG_DIVIDE_MODE:   r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_UPD) begin
                r_seen <= r_rst;
                r_last <= r_clk;
                r_dcnt <= cnt_n;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_TAKE: begin
                r_clk  <= i_in_data[15:0];
                r_beat <= i_in_data[31:16];
                r_rst  <= i_in_user[0];
                r_play <= i_in_user[1];
            end
            OP_UPD: begin
                r_ph  <= mul_p[15:0] + r_shift;
                r_num <= num_n;
                r_rem <= '0;
                r_div <= div_f;
                r_lvl <= LVL_W'(signed'(r_offs));
            end
            OP_DIV: begin
                r_rem <= ge ? RW'(trial - {1'b0, r_div}) : RW'(trial);
                r_num <= {r_num[30:0], ge};
            end
            OP_PHD: r_ph <= r_num[15:0] + r_shift;
            OP_CRV1: begin
                r_p    <= p_f;
                r_zero <= (r_ph == 16'd0);
                r_log  <= log_rom[mant[15:TSHIFT]];
                r_exp  <= exp_rom[exp_idx];
            end
            OP_CRV2: r_nz <= mul_p[38:16];
            OP_CRV3: begin
                r_big <= r_nz >= (23'd40 << 16);
                r_sh  <= r_nz[21:16] + {5'd0, r_nz[15:0] != 16'd0};
                r_val <= (r_nz[15:0] == 16'd0) ? 17'd65536 : exp_rom[exp_idx];
            end
            OP_CRV4: begin
                logic [15:0] yv;
                yv = (r_zero || r_big) ? 16'd0
                   : (ysh > 17'd65535) ? 16'hFFFF : ysh[15:0];
                r_y <= yv;
                if (r_shape == SHAPE_TRIANGLE)
                    r_u <= (yv < 16'd32768) ? {yv, 1'b0} : {17'd65536 - 17'(yv)} << 1;
                else
                    r_u <= 17'(yv);
            end
            OP_SQR: r_u <= (r_ph < r_warp) ? 17'd0 : 17'd65536;
            OP_SN0: begin
                r_z  <= z_sel;
                r_z2 <= mul_p[32:16];
            end
            OP_SN1: r_a <= 17'd5223 - mul_p[32:16];
            OP_SN2: r_a <= 17'd42334 - mul_p[32:16];
            OP_SN3: r_a <= 17'd102944 - mul_p[32:16];
            OP_SN4: r_u <= r_y[15] ? 17'd32768 - (s_f >> 1) : 17'd32768 + (s_f >> 1);
            OP_SCL1: begin
                r_prd <= mul_p[24:0];
                r_neg <= r_scale[7];
            end
            OP_SCL2: r_q <= mul_p[34:18];
            OP_COR: begin
                if (lv > 19'sd61440) r_lvl <= LVL_W'(LVL_LIMIT);
                else if (lv < -19'sd61440) r_lvl <= LVL_W'(-LVL_LIMIT);
                else r_lvl <= lv[LVL_W-1:0];
            end
            OP_LOAD: r_out <= r_lvl;
            default: ;
        endcase
    end

    assign o_stat.play     = r_play;
    assign o_stat.mul_mode = is_mul;
    assign o_stat.shape    = r_shape;
    assign o_level         = r_out;

endmodule

/* design/clock_synced_lfo_channel.sv */
// Top level of one clock-synced LFO channel: sequencer plus datapath.
//
//  Channel   Direction  Handshake              Contents
//  s_axis    in         tvalid/tready          tdata: clock_phase, beat_number; tuser: flags
//  m_axis    out        tvalid/tready          tdata: level_out (17-bit signed)
//  cfg       in         i_cfg_we, no wait      register index and 16-bit data
//
// A stopped item goes from acceptance through the update step straight to a loaded
// result. A playing item in multiply mode runs the curve, scale and correction steps
// (square swaps the curve steps for a square step, sine adds its sine steps); divide
// mode adds the bit-serial 32-bit restoring divider and a phase step, so a sine in
// divide mode is the longest case. Reset is synchronous and active low.
// The input is refused while an item is in work; a waiting result is held in
// its own register, so a stalled output costs the next item nothing until it
// finishes and needs that register.
`include "clock_synced_lfo_channel_macros.svh"
module clock_synced_lfo_channel #(
    parameter int MAX_RATIO  = cslfo_pkg::CSLFO_MAX_RATIO,
    parameter int TABLE_BITS = cslfo_pkg::CSLFO_TABLE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Bits 15:0 clock_phase, 31:16 beat_number.
    input  logic [31:0]                      s_axis_tdata,
    // Bit 0 restart_level, bit 1 playing.
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Bits 16:0 level_out, bits 23:17 zero.
    output logic [23:0]                      m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [cslfo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cslfo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cslfo_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic [LVL_W-1:0] level;

    // The sequencer owns the handshakes and the word valid flag.
    cslfo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds configuration, channel state and all arithmetic.
    cslfo_dpath #(
        .MAX_RATIO  (MAX_RATIO),
        .TABLE_BITS (TABLE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_level    (level)
    );

    assign m_axis_tdata = {{(24 - LVL_W){1'b0}}, level};

    // An accepted word keeps the input closed in the following cycle.
    `CSLFO_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Every delivered level lies inside the saturation range.
    `CSLFO_ASSERT(a_level_range, !m_axis_tvalid || ($signed(level) <= 17'sd61440 && $signed(level) >= -17'sd61440))
    // A fresh result only appears after the channel was busy.
    `CSLFO_ASSERT(a_result_from_work, !$rose(m_axis_tvalid) || !$past(s_axis_tready))

endmodule

/* tb/tb_clock_synced_lfo_channel.sv */
// Self-checking testbench for one clock-synced LFO channel with a bit-exact predictor.
module tb_clock_synced_lfo_channel;
    import cslfo_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;

    typedef struct {
        logic [15:0] clk_ph;
        logic [15:0] beat;
        logic        restart;
        logic        play;
    } tick_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    clock_synced_lfo_channel dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow copy of the channel registers and running state.
    logic [1:0]  sh_shape;
    logic [6:0]  sh_rate;
    logic [15:0] sh_shift;
    logic [15:0] sh_warp;
    logic [15:0] sh_offset;
    logic [7:0]  sh_scale;
    logic        sh_invert;
    logic        sh_loop;
    logic [5:0]  st_count;
    logic [15:0] st_last_ph;
    logic        st_restart;

    bit [31:0] log2_lut [1024];
    bit [31:0] exp2_lut [1024];

    tick_t       tick_q [$];
    logic [16:0] level_q [$];
    int          err_count = 0;
    bit          burst_mode = 0;
    bit          stall_req = 0;
    int          stall_left = 0;
    int          cycle_count = 0;

    function automatic bit [63:0] int_sqrt(bit [63:0] a);
        bit [63:0] v, res, b;
        v = a;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Fill the log2 and exp2 lookup tables exactly as the channel builds them.
    task automatic build_luts();
        bit [63:0] roots [17];
        bit [63:0] y, acc;
        bit [31:0] r, f;
        roots[0] = 64'd2 << 30;
        for (int i = 1; i <= 16; i++) roots[i] = int_sqrt(roots[i-1] << 30);
        for (int k = 0; k < 1024; k++) begin
            y = (64'd1 << 30) + (64'(k) << 20);
            acc = 64'd1 << 30;
            r = 0;
            f = k << 6;
            for (int i = 0; i < 16; i++) begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd2 << 30)) begin
                    y = y >> 1;
                    r[0] = 1'b1;
                end
            end
            log2_lut[k] = r;
            for (int i = 1; i <= 16; i++)
                if (f[16-i]) acc = (acc * roots[i]) >> 30;
            exp2_lut[k] = 32'(acc >> 14);
        end
    endtask

    // Power curve x^(2^(4w-2)) on a Q0.16 phase.
    function automatic bit [31:0] power_curve(bit [31:0] x, bit [31:0] w);
        int p;
        bit [31:0] m, lmag, t, ip, e, frac, sh;
        bit [63:0] nz, val, y;
        if (x == 0) return 0;
        p = 15;
        while (x[p] == 1'b0) p--;
        m = (x << (16 - p)) - 32'd65536;
        lmag = (16 - p) * 32'd65536 - log2_lut[(m >> 6) & 1023];
        t = 4 * w;
        ip = t >> 16;
        e = (exp2_lut[((t & 32'hFFFF) >> 6) & 1023] << ip) >> 2;
        nz = (64'(lmag) * e) >> 16;
        frac = 32'(nz & 64'hFFFF);
        if (nz >= (64'd40 << 16)) return 0;
        sh = 32'(nz >> 16);
        if (frac == 0) begin
            val = 65536;
        end else begin
            sh++;
            val = exp2_lut[((32'd65536 - frac) >> 6) & 1023];
        end
        y = val >> sh;
        return (y > 65535) ? 32'd65535 : 32'(y);
    endfunction

    function automatic bit [31:0] sine_of(bit [31:0] y);
        bit [31:0] q, r, z, z2, s;
        bit [63:0] acc;
        q = (y >> 14) & 3;
        r = y & 32'h3FFF;
        z = q[0] ? ((32'd16384 - r) << 2) : (r << 2);
        z2 = 32'((64'(z) * z) >> 16);
        acc = 64'd5223 - ((64'(z2) * 307) >> 16);
        acc = 64'd42334 - ((64'(z2) * acc) >> 16);
        acc = 64'd102944 - ((64'(z2) * acc) >> 16);
        acc = (64'(z) * acc) >> 16;
        s = (acc > 65536) ? 32'd65536 : 32'(acc);
        return q[1] ? 32'd32768 - (s >> 1) : 32'd32768 + (s >> 1);
    endfunction

    // Advance the shadow state by one sample tick and return the expected level.
    function automatic logic [16:0] next_level(tick_t t);
        int rate, offs, scale;
        bit [31:0] mul, dv, ph, u, y;
        bit [63:0] num;
        longint lvl;
        bit wrapped;
        rate = int'($signed(sh_rate));
        offs = int'($signed(sh_offset));
        scale = int'($signed(sh_scale));
        if (t.restart && !st_restart) begin
            st_count = 0;
            st_last_ph = t.clk_ph;
        end
        st_restart = t.restart;
        wrapped = t.clk_ph < st_last_ph;
        st_last_ph = t.clk_ph;
        if (!t.play) return 17'(offs);
        if (rate >= -1) begin
            mul = (rate < 1) ? 1 : rate;
            if (mul > CSLFO_MAX_RATIO) mul = CSLFO_MAX_RATIO;
            ph = (t.clk_ph * mul + sh_shift) & 32'hFFFF;
        end else begin
            dv = -rate;
            if (dv > CSLFO_MAX_RATIO) dv = CSLFO_MAX_RATIO;
            if (wrapped) begin
                st_count = st_count + 1;
                if (st_count >= dv) st_count = 0;
            end
            if (!sh_loop) num = (64'(t.beat) << 16) + t.clk_ph;
            else num = (64'(st_count) << 16) + t.clk_ph;
            ph = 32'((num / dv + sh_shift) & 64'hFFFF);
        end
        case (t_shape'(sh_shape))
            SHAPE_RAMP: u = power_curve(ph, sh_warp);
            SHAPE_TRIANGLE: begin
                y = power_curve(ph, sh_warp);
                u = (y < 32768) ? 2 * y : 2 * (32'd65536 - y);
            end
            SHAPE_SINE: u = sine_of(power_curve(ph, sh_warp));
            default: u = (ph < sh_warp) ? 0 : 65536;
        endcase
        if (sh_invert) u = 32'd65536 - u;
        lvl = (longint'(u) * scale) / 160 + offs;
        if (lvl > LVL_LIMIT) lvl = LVL_LIMIT;
        if (lvl < -LVL_LIMIT) lvl = -LVL_LIMIT;
        return 17'(lvl);
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Sender: feeds words from tick_q, with a random gap after each accepted word outside burst mode.
    int    send_gap = 0;
    tick_t cur_tick;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                level_q.push_back(next_level(cur_tick));
                send_gap = burst_mode ? 0 : $urandom_range(0, 9);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // Word still on offer; hold it.
            end else if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                cur_tick = tick_q.pop_front();
                s_axis_tdata <= {cur_tick.beat, cur_tick.clk_ph};
                s_axis_tuser <= {cur_tick.play, cur_tick.restart};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    always @(posedge i_clk) begin
        if (stall_req) stall_left <= 400;
        else if (stall_left > 0) stall_left <= stall_left - 1;
    end

    // Receiver: checks each result word against the oldest expected level.
    int recv_gap = 0;
    logic [16:0] want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (level_q.size() == 0) begin
                    report_mismatch("result word with no expected level");
                end else begin
                    want = level_q.pop_front();
                    if (m_axis_tdata[16:0] !== want)
                        report_mismatch($sformatf("level_out got %0d want %0d",
                            $signed(m_axis_tdata[16:0]), $signed(want)));
                end
                recv_gap = burst_mode ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Registers are only written while the channel is idle.
    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_WAVE_SHAPE:    sh_shape = data[1:0];
            CFG_RATE_SETTING:  sh_rate = data[6:0];
            CFG_PHASE_SHIFT:   sh_shift = data;
            CFG_WARP_AMOUNT:   sh_warp = data;
            CFG_LEVEL_OFFSET:  sh_offset = data;
            CFG_SCALE_PERCENT: sh_scale = data[7:0];
            CFG_INVERT_WAVE:   sh_invert = data[0];
            default:           sh_loop = data[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] shp, logic [15:0] rate, logic [15:0] shift,
                             logic [15:0] warp, logic [15:0] offs, logic [15:0] scl,
                             logic [15:0] inv, logic [15:0] lp);
        write_reg(CFG_WAVE_SHAPE, shp);
        write_reg(CFG_RATE_SETTING, rate);
        write_reg(CFG_PHASE_SHIFT, shift);
        write_reg(CFG_WARP_AMOUNT, warp);
        write_reg(CFG_LEVEL_OFFSET, offs);
        write_reg(CFG_SCALE_PERCENT, scl);
        write_reg(CFG_INVERT_WAVE, inv);
        write_reg(CFG_DIVIDE_MODE, lp);
    endtask

    task automatic add_tick(logic [15:0] c, logic [15:0] b, logic r, logic p);
        tick_t t;
        t.clk_ph = c;
        t.beat = b;
        t.restart = r;
        t.play = p;
        tick_q.push_back(t);
    endtask

    // Let every queued word through and every expected level arrive.
    task automatic drain();
        while (tick_q.size() > 0 || s_axis_tvalid || level_q.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Mostly a running master clock with wraps, beats and restarts; some noise.
    task automatic add_random_ticks(int count);
        logic [15:0] c, b;
        int step;
        logic r;
        c = $urandom;
        b = $urandom;
        r = 0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_tick($urandom, $urandom, $urandom, $urandom);
            end else begin
                step = ($urandom_range(0, 3) == 0) ? $urandom_range(8000, 40000)
                                                   : $urandom_range(1, 6000);
                if (32'(c) + step > 65535) b++;
                c = c + 16'(step);
                if ($urandom_range(0, 29) == 0) r = ~r;
                else if (r && $urandom_range(0, 2) == 0) r = 0;
                add_tick(c, b, r, $urandom_range(0, 11) != 0);
            end
        end
    endtask

    initial begin
        build_luts();
        sh_shape = 0; sh_rate = 0; sh_shift = 0; sh_warp = 16'd32768;
        sh_offset = 0; sh_scale = 8'd100; sh_invert = 0; sh_loop = 0;
        st_count = 0; st_last_ph = 0; st_restart = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: field extremes, stopped ticks, restart and wrap corners.
        add_tick(16'h0000, 16'h0000, 0, 1);
        add_tick(16'hFFFF, 16'hFFFF, 0, 1);
        add_tick(16'h0001, 16'h0000, 0, 1);
        add_tick(16'h8000, 16'h0001, 1, 1);
        add_tick(16'h7000, 16'h0001, 1, 0);
        add_tick(16'h1000, 16'h0002, 0, 0);
        add_tick(16'h0800, 16'h0002, 1, 1);
        drain();

        // Loop division past the ratio limit with stale counts, inverted sine.
        write_all(SHAPE_SINE, 16'h0040, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h007F, 1, 1);
        for (int n = 0; n < 8; n++) add_tick(16'(n * 40000), 16'(n), n == 5, 1);
        drain();

        // Multiply past the limit, square at both pulse-width extremes.
        write_all(SHAPE_SQUARE, 16'h003F, 16'h0000, 16'hFFFF, 16'h8000, 16'h0080, 0, 0);
        add_tick(16'hFFFE, 16'hFFFF, 0, 1);
        add_tick(16'h0000, 16'h0000, 0, 1);
        drain();
        write_reg(CFG_WARP_AMOUNT, 16'h0000);
        add_tick(16'h0000, 16'h0000, 0, 1);
        add_tick(16'hFFFF, 16'h1234, 0, 1);
        drain();

        // Random settings, sometimes with fields outside their nominal ranges.
        for (int ph = 0; ph < 12; ph++) begin
            write_all($urandom_range(0, 3),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                  : 16'($urandom_range(0, 64) - 32),
                      $urandom, $urandom,
                      ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 40960) - 20480),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                  : 16'($urandom_range(0, 200) - 100),
                      $urandom_range(0, 1), $urandom_range(0, 1));
            burst_mode = (ph % 4 == 1);
            if (ph == 6) begin
                burst_mode = 1;
                @(posedge i_clk);
                stall_req <= 1'b1;
                @(posedge i_clk);
                stall_req <= 1'b0;
            end
            add_random_ticks(100);
            drain();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
